// File: rtl/wcrc_pkg.sv
// Shared types, constants and CRC functions for the word CRC-16 block.
// No dependencies; used by the top level, front end, queue and back end of the block.
`default_nettype none
package wcrc_pkg;

    localparam logic [1:0]  MODE_PLAIN  = 2'd0;
    localparam logic [1:0]  MODE_LOADER = 2'd1;
    localparam logic [1:0]  MODE_ARM9   = 2'd2;

    localparam logic        CFG_MODE    = 1'b0;
    localparam logic        CFG_COUNT   = 1'b1;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  ODD_ENTRY   = 8'd246;
    localparam logic [15:0] MARK_FIRST  = 16'h2F3F;
    localparam logic [15:0] MARK_SECOND = 16'h4023;
    localparam logic [11:0] WIN_LOW     = 12'h900;
    localparam logic [11:0] WIN_HIGH    = 12'h200;
    localparam logic [2:0]  SKIP_RELOAD = 3'd7;
    localparam logic [3:0]  MARK_SPAN   = 4'd8;

    localparam int          QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       fold0_en;
        logic [7:0] fold0_byte;
        logic       fold1_en;
        logic [7:0] fold1_byte;
        logic       std_entry;
        logic       last;
        logic       ended_early;
    } t_fold_op;

    function automatic logic [15:0] crc_entry(input logic [7:0] idx);
        logic [15:0] e;
        e = {8'h00, idx};
        for (int b = 0; b < 8; b++) begin
            e = e[0] ? ((e >> 1) ^ CRC_POLY) : (e >> 1);
        end
        return e;
    endfunction

    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic        std_entry);
        logic [7:0]  idx;
        logic [15:0] e;
        idx = crc[7:0] ^ data;
        e   = crc_entry(idx);
        if (idx == ODD_ENTRY && !std_entry) begin
            e[0] = 1'b1;
        end
        return e ^ {8'h00, crc[15:8]};
    endfunction

endpackage
`default_nettype wire

// File: rtl/word_crc16_with_region_skip.sv
// The result register takes the checksum as the last word's operation leaves the queue.
// Throughput: one word per cycle while the queue is not full; each operation folds as it pops.
// Input is stalled only while the two-entry queue is full, i.e. while the result waits.
// Reset is synchronous and active low; it clears the CRC, position, queue and result flag.
// Top level; depends on wcrc_pkg, wcrc_front, wcrc_queue and wcrc_back.
`default_nettype none
module word_crc16_with_region_skip #(
    parameter int COUNT_BITS = 20
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_index,
    input  wire  [COUNT_BITS-1:0]   i_cfg_wdata,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [15:0]             s_axis_tdata,   // [15:0] word
    input  wire                     s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [15:0]             m_axis_tdata,   // [15:0] checksum
    output logic                    m_axis_tuser    // [0] ended_early
);
    import wcrc_pkg::*;

    logic     accept;
    logic     q_not_full;
    logic     q_valid;
    logic     q_pop;
    t_fold_op front_op;
    t_fold_op back_op;

    assign s_axis_tready = q_not_full;
    assign accept        = s_axis_tvalid && q_not_full;

    wcrc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_word      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_op        (front_op)
    );

    wcrc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_op       (front_op),
        .o_not_full (q_not_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_op       (back_op)
    );

    wcrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_op          (back_op),
        .o_pop         (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_checksum    (m_axis_tdata),
        .o_ended_early (m_axis_tuser)
    );

endmodule
`default_nettype wire

// File: rtl/wcrc_front.sv
// Front end: configuration registers, position tracking, lookahead, marker and window skips.
// Turns each accepted word into a fold operation; depends on wcrc_pkg.
`default_nettype none
module wcrc_front #(
    parameter int COUNT_BITS = 20
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_index,
    input  wire  [COUNT_BITS-1:0]   i_cfg_wdata,
    input  wire                     i_accept,
    input  wire  [15:0]             i_word,
    input  wire                     i_last,
    output wcrc_pkg::t_fold_op      o_op
);
    import wcrc_pkg::*;

    localparam int P = COUNT_BITS + 1;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    logic [1:0]            r_mode;
    logic [COUNT_BITS-1:0] r_count;
    logic [P-1:0]          r_pos,        n_pos;
    logic [15:0]           r_held_word,  n_held_word;
    logic                  r_held_valid, n_held_valid;
    logic [2:0]            r_skip_left,  n_skip_left;
    logic                  r_finished,   n_finished;

    logic [P-1:0] cnt_ext;
    logic [P-1:0] q_prev;
    logic [P:0]   q_span;
    logic         win_en;
    logic [P-1:0] win_lo;
    logic [P-1:0] win_hi;
    t_fold_op     op;

    function automatic logic in_win(input logic [P-1:0] q, input logic en,
                                    input logic [P-1:0] lo, input logic [P-1:0] hi);
        return en && (q > lo) && (q < hi);
    endfunction

    assign cnt_ext = {1'b0, r_count};
    assign q_prev  = (r_pos != '0) ? r_pos - P'(1) : '0;
    assign q_span  = {1'b0, q_prev} + (P+1)'(MARK_SPAN);
    assign win_en  = cnt_ext >= P'(WIN_LOW);
    assign win_lo  = cnt_ext - P'(WIN_LOW);
    assign win_hi  = cnt_ext - P'(WIN_HIGH);

    always_comb begin
        n_pos        = r_pos;
        n_held_word  = r_held_word;
        n_held_valid = r_held_valid;
        n_skip_left  = r_skip_left;
        n_finished   = r_finished;
        op           = '0;
        op.std_entry = (r_mode == MODE_LOADER);
        if (i_accept) begin
            if (r_held_valid) begin
                n_held_valid = 1'b0;
                if (r_held_word == MARK_FIRST && i_word == MARK_SECOND) begin
                    n_skip_left = SKIP_RELOAD;
                    if (q_span >= {1'b0, cnt_ext}) begin
                        n_finished = 1'b1;
                    end
                end else if (!in_win(q_prev, win_en, win_lo, win_hi)) begin
                    op.fold0_en   = 1'b1;
                    op.fold0_byte = r_held_word[7:0];
                end
            end
            if (n_finished) begin
                n_skip_left = n_skip_left;
            end else if (n_skip_left != 3'd0) begin
                n_skip_left = n_skip_left - 3'd1;
            end else if (r_pos < cnt_ext) begin
                if (r_mode == MODE_ARM9) begin
                    n_held_word  = i_word;
                    n_held_valid = 1'b1;
                end else begin
                    op.fold1_en   = 1'b1;
                    op.fold1_byte = i_word[7:0];
                end
            end
            n_pos = (r_pos != POS_MAX) ? r_pos + P'(1) : r_pos;
            if (i_last) begin
                if (n_held_valid && !n_finished && !in_win(r_pos, win_en, win_lo, win_hi)) begin
                    op.fold1_en   = 1'b1;
                    op.fold1_byte = n_held_word[7:0];
                end
                op.last        = 1'b1;
                op.ended_early = n_finished;
                n_pos          = '0;
                n_held_word    = '0;
                n_held_valid   = 1'b0;
                n_skip_left    = 3'd0;
                n_finished     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PLAIN;
            r_count      <= '0;
            r_pos        <= '0;
            r_held_word  <= '0;
            r_held_valid <= 1'b0;
            r_skip_left  <= 3'd0;
            r_finished   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) begin
                    r_mode <= i_cfg_wdata[1:0];
                end else begin
                    r_count <= i_cfg_wdata;
                end
            end
            r_pos        <= n_pos;
            r_held_word  <= n_held_word;
            r_held_valid <= n_held_valid;
            r_skip_left  <= n_skip_left;
            r_finished   <= n_finished;
        end
    end

    assign o_op = op;

endmodule
`default_nettype wire

// File: rtl/wcrc_queue.sv
// Short queue of fold operations between the front end and the CRC back end.
// Depends on wcrc_pkg for the operation type and depth.
`default_nettype none
module wcrc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wcrc_pkg::t_fold_op  i_op,
    output logic                o_not_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output wcrc_pkg::t_fold_op  o_op
);
    import wcrc_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_fold_op        r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_fill;

    assign o_not_full = r_fill != (AW+1)'(QUEUE_DEPTH);
    assign o_valid    = r_fill != '0;
    assign o_op       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/wcrc_back.sv
// Back end: applies up to two byte folds per operation and holds the result register.
// Depends on wcrc_pkg for the fold function and operation type.
`default_nettype none
module wcrc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wcrc_pkg::t_fold_op  i_op,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_checksum,
    output logic                o_ended_early
);
    import wcrc_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] crc_a;
    logic [15:0] crc_b;
    logic        r_out_valid;
    logic [15:0] r_out_crc;
    logic        r_out_early;

    assign o_pop = i_valid && (!i_op.last || !r_out_valid || i_ready);
    assign crc_a = i_op.fold0_en ? crc_fold(r_crc, i_op.fold0_byte, i_op.std_entry) : r_crc;
    assign crc_b = i_op.fold1_en ? crc_fold(crc_a, i_op.fold1_byte, i_op.std_entry) : crc_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_op.last) begin
                    r_crc       <= CRC_INIT;
                    r_out_valid <= 1'b1;
                end else begin
                    r_crc <= crc_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.last) begin
            r_out_crc   <= crc_b;
            r_out_early <= i_op.ended_early;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_checksum    = r_out_crc;
    assign o_ended_early = r_out_early;

endmodule
`default_nettype wire

// File: rtl/wcrc_checker.sv
// Port-level checks for the word CRC-16 block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module wcrc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tuser
);

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid directly after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready directly after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind word_crc16_with_region_skip wcrc_checker u_wcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: sim/wcrc_run_monitor.sv
// Run monitor for the word CRC-16 block: it follows configuration writes and accepted words,
// predicts each run's checksum and early-end flag, and compares them with the output stream.
// Depends on wcrc_pkg for the mode codes, register indexes and CRC constants.
module wcrc_run_monitor (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_index,
    input  wire  [19:0]  i_cfg_wdata,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire  [15:0]  i_in_word,
    input  wire          i_in_last,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire  [15:0]  i_out_checksum,
    input  wire          i_out_early,
    output int           o_mismatches,
    output int           o_pending,
    output int           o_results,
    output int           o_early
);
    timeunit 1ns;
    timeprecision 1ps;
    import wcrc_pkg::*;

    localparam logic [20:0] POS_TOP = '1;

    typedef struct packed {
        logic [15:0] checksum;
        logic        ended_early;
    } t_run_result;

    t_run_result checksums_due[$];

    logic [1:0]  mode_reg;
    logic [19:0] count_reg;
    logic [15:0] crc_acc;
    logic [20:0] word_pos;
    logic [15:0] held;
    logic        held_ok;
    logic [2:0]  skip_cnt;
    logic        done_early;
    int          fault_count;
    int          result_count;
    int          early_count;

    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data,
                                                  input logic [1:0]  m);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        // The altered table sets the low bit of one entry, which is clear in the standard one.
        if ((crc[7:0] ^ data) == ODD_ENTRY && m != MODE_LOADER) begin
            r[0] = ~r[0];
        end
        return r;
    endfunction

    function automatic bit in_skip_window(input int unsigned q, input int unsigned cnt);
        if (cnt < WIN_LOW) begin
            return 1'b0;
        end
        return q > cnt - WIN_LOW && q < cnt - WIN_HIGH;
    endfunction

    task automatic clear_run();
        crc_acc    = CRC_INIT;
        word_pos   = '0;
        held       = '0;
        held_ok    = 1'b0;
        skip_cnt   = '0;
        done_early = 1'b0;
    endtask

    task automatic resolve_held(input int unsigned q, input bit have_next,
                                input logic [15:0] nxt);
        held_ok = 1'b0;
        if (have_next && held == MARK_FIRST && nxt == MARK_SECOND) begin
            skip_cnt = SKIP_RELOAD;
            if (q + MARK_SPAN >= count_reg) begin
                done_early = 1'b1;
            end
        end else if (!in_skip_window(q, 32'(count_reg))) begin
            crc_acc = crc_fold_byte(crc_acc, held[7:0], mode_reg);
        end
    endtask

    task automatic advance_word(input logic [15:0] w, input logic last);
        int unsigned pos;
        t_run_result res;
        pos = 32'(word_pos);
        if (held_ok) begin
            resolve_held(pos > 0 ? pos - 1 : 0, 1'b1, w);
        end
        if (done_early) begin
        end else if (skip_cnt != 0) begin
            skip_cnt = skip_cnt - 3'd1;
        end else if (pos < count_reg) begin
            if (mode_reg == MODE_ARM9) begin
                held    = w;
                held_ok = 1'b1;
            end else begin
                crc_acc = crc_fold_byte(crc_acc, w[7:0], mode_reg);
            end
        end
        if (word_pos != POS_TOP) begin
            word_pos = word_pos + 21'd1;
        end
        if (last) begin
            if (held_ok && !done_early) begin
                resolve_held(pos, 1'b0, '0);
            end
            res.checksum    = crc_acc;
            res.ended_early = done_early;
            checksums_due.push_back(res);
            clear_run();
        end
    endtask

    always @(posedge i_clk) begin
        t_run_result want;
        if (!i_rst_n) begin
            mode_reg  = MODE_PLAIN;
            count_reg = '0;
            clear_run();
            checksums_due.delete();
            fault_count  = 0;
            result_count = 0;
            early_count  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (checksums_due.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("Unexpected result: checksum %h ended_early %b",
                                 i_out_checksum, i_out_early);
                    end
                    fault_count++;
                end else begin
                    want = checksums_due.pop_front();
                    result_count++;
                    if (want.ended_early) begin
                        early_count++;
                    end
                    if (want.checksum !== i_out_checksum ||
                        want.ended_early !== i_out_early) begin
                        if (fault_count < 10) begin
                            $display({"Result %0d wrong: expected checksum %h ",
                                      "ended_early %b, got %h %b"},
                                     result_count, want.checksum, want.ended_early,
                                     i_out_checksum, i_out_early);
                        end
                        fault_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) begin
                    mode_reg = i_cfg_wdata[1:0];
                end else begin
                    count_reg = i_cfg_wdata;
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_word(i_in_word, i_in_last);
            end
        end
        o_mismatches <= fault_count;
        o_pending    <= checksums_due.size();
        o_results    <= result_count;
        o_early      <= early_count;
    end

endmodule

// File: sim/word_crc16_with_region_skip_test.sv
// Top of the word CRC-16 testbench: clock, reset, configuration, word stimulus and verdict.
// Depends on wcrc_pkg, the block word_crc16_with_region_skip and the monitor wcrc_run_monitor.
module word_crc16_with_region_skip_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wcrc_pkg::*;

    localparam int         WORD_TARGET = 950;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [19:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire         m_axis_tuser;

    int          mon_mismatches;
    int          mon_pending;
    int          mon_results;
    int          mon_early;

    int          cycles        = 0;
    int          words_sent    = 0;
    bit          calm          = 1'b0;
    bit          hold_req      = 1'b0;

    word_crc16_with_region_skip #(.COUNT_BITS(20)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wcrc_run_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_word      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_checksum (m_axis_tdata),
        .i_out_early    (m_axis_tuser),
        .o_mismatches   (mon_mismatches),
        .o_pending      (mon_pending),
        .o_results      (mon_results),
        .o_early        (mon_early)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d checksums outstanding",
                     cycles, mon_pending);
            $display("** word_crc16_with_region_skip: FAILED **");
            $finish;
        end
    end

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 9))
            0:       return MARK_FIRST;
            1:       return MARK_SECOND;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [15:0] w, input logic last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_words(input logic [15:0] ws[$]);
        for (int i = 0; i < ws.size(); i++) begin
            send_word(ws[i], i == ws.size() - 1);
        end
    endtask

    task automatic send_run(input int len, input bit marked);
        logic [15:0] ws[$];
        int at;
        for (int i = 0; i < len; i++) begin
            ws.push_back(random_word());
        end
        if (marked && len >= 2) begin
            at = $urandom_range(0, len - 2);
            ws[at]     = MARK_FIRST;
            ws[at + 1] = MARK_SECOND;
        end
        for (int i = 0; i < len; i++) begin
            send_word(ws[i], i == len - 1);
        end
    endtask

    // Waits until every checksum has come out, then lets the pipeline run empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mon_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [19:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_wdata <= {18'($urandom), mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_COUNT;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (120) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [1:0]  mode;
        logic [19:0] count;
        int          len;
        bit          squeezed;
        squeezed = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A first word of 0x09 against the start value lands on the altered table entry.
        set_config(MODE_PLAIN, 20'hFFFFF);
        send_words('{16'h0009, 16'hFFFF, 16'h0000});
        settle();
        set_config(MODE_LOADER, 20'hFFFFF);
        send_words('{16'hFF09});
        settle();
        set_config(MODE_SPARE, 20'hFFFFF);
        send_words('{16'h0009});
        settle();
        set_config(MODE_ARM9, 20'd16);
        send_words('{MARK_FIRST, MARK_SECOND, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                     16'h0F0F, 16'hF0F0, 16'hA5A5});
        send_words('{16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505, 16'h0606,
                     16'h0707, 16'h0808, MARK_FIRST, MARK_SECOND, 16'h0909});
        send_words('{MARK_FIRST});
        settle();

        // One run crosses the lower edge of the skipped window.
        set_config(MODE_ARM9, 20'h902);
        send_run(40, 1'b1);

        while (words_sent < WORD_TARGET) begin
            settle();
            if (!squeezed && words_sent >= 300) begin
                squeezed = 1'b1;
                set_config(MODE_ARM9, 20'd30);
                hold_req = 1'b1;
                repeat (12) send_run($urandom_range(1, 3), 1'b1);
                settle();
            end
            calm = words_sent >= WORD_TARGET - 150;
            case ($urandom_range(0, 5))
                0:       mode = MODE_PLAIN;
                1:       mode = MODE_LOADER;
                5:       mode = MODE_SPARE;
                default: mode = MODE_ARM9;
            endcase
            case ($urandom_range(0, 6))
                0:       count = '0;
                1:       count = 20'($urandom_range(1, 40));
                2:       count = 20'(20'h900 + $urandom_range(0, 40));
                3:       count = 20'hFFFFF;
                4:       count = 20'($urandom_range(0, 20'hFFFFF));
                default: count = 20'($urandom_range(8, 24));
            endcase
            set_config(mode, count);
            repeat ($urandom_range(1, 5)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(1, 40);
                send_run(len, mode == MODE_ARM9 ? $urandom_range(0, 3) != 0
                                                : $urandom_range(0, 1) != 0);
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        $display("Sent %0d words over all four mode codes and word counts up to the maximum,",
                 words_sent);
        $display({"with the skipped window and a long output stall; ",
                  "%0d checksums checked, %0d ended early."},
                 mon_results, mon_early);
        if (mon_mismatches == 0 && mon_pending == 0) begin
            $display("** word_crc16_with_region_skip: PASSED **");
        end else begin
            $display("%0d mismatches, %0d checksums never arrived", mon_mismatches, mon_pending);
            $display("** word_crc16_with_region_skip: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/wcrc_pkg.sv
rtl/wcrc_front.sv
rtl/wcrc_queue.sv
rtl/wcrc_back.sv
rtl/word_crc16_with_region_skip.sv
rtl/wcrc_checker.sv
sim/wcrc_run_monitor.sv
sim/word_crc16_with_region_skip_test.sv
